### rtl/core/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, register codes and reset constants of the sensorless BLDC
// six-step commutator.
// ----------------------------------------------------------------------------
package sbc_pkg;

  // Phase codes on the drive outputs
  localparam logic [1:0] PHASE_A    = 2'd0;
  localparam logic [1:0] PHASE_B    = 2'd1;
  localparam logic [1:0] PHASE_C    = 2'd2;
  localparam logic [1:0] PHASE_NONE = 2'd3;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MIN_DUTY         = 3'd0,
    CFG_MAX_DUTY         = 3'd1,
    CFG_START_DUTY       = 3'd2,
    CFG_DUTY_INCREMENT   = 3'd3,
    CFG_DEBOUNCE_SAMPLES = 3'd4,
    CFG_FIRST_DELAY_MS   = 3'd5,
    CFG_STEPS_PER_STAGE  = 3'd6,
    CFG_BUTTON_REPEAT_MS = 3'd7
  } cfg_index_t;

  localparam int CFG_DATA_W = 10;

  // Register reset values
  localparam logic [7:0] RST_MIN_DUTY         = 8'd30;
  localparam logic [7:0] RST_MAX_DUTY         = 8'd250;
  localparam logic [7:0] RST_START_DUTY       = 8'd100;
  localparam logic [5:0] RST_DUTY_INCREMENT   = 6'd5;
  localparam logic [3:0] RST_DEBOUNCE_SAMPLES = 4'd10;
  localparam logic [5:0] RST_FIRST_DELAY_MS   = 6'd22;
  localparam logic [5:0] RST_STEPS_PER_STAGE  = 6'd30;
  localparam logic [9:0] RST_BUTTON_REPEAT_MS = 10'd500;

  typedef struct packed {
    logic [7:0] min_duty;
    logic [7:0] max_duty;
    logic [7:0] start_duty;
    logic [5:0] duty_increment;
    logic [3:0] debounce_samples;
    logic [5:0] first_start_delay_ms;
    logic [5:0] steps_per_stage;
    logic [9:0] button_repeat_ms;
  } cfg_t;

  // Controller modes, one-hot
  typedef enum logic [3:0] {
    MODE_START_COMMUTATE = 4'b0001,
    MODE_START_WAIT      = 4'b0010,
    MODE_RUN_EDGE        = 4'b0100,
    MODE_RUN_COUNT       = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [1:0] high_side;
    logic [1:0] low_side;
    logic [1:0] sense;
    logic       rising;
  } drive_t;

  // All switches off, sense C rising
  localparam drive_t DRIVE_OFF = '{high_side: PHASE_NONE, low_side: PHASE_NONE,
                                   sense: PHASE_C, rising: 1'b1};

  typedef struct packed {
    logic [2:0] step_index;
    mode_t      mode;
    logic [5:0] stage_delay;
    logic [5:0] stage_count;
    logic [9:0] wait_count;
    logic [3:0] match_count;
    logic [7:0] duty_level;
    logic       prev_level;
    logic       down_turn;
    drive_t     drive;
  } state_t;

  localparam state_t STATE_RESET = '{
    step_index:  3'd0,
    mode:        MODE_START_COMMUTATE,
    stage_delay: RST_FIRST_DELAY_MS,
    stage_count: 6'd0,
    wait_count:  10'd0,
    match_count: 4'd0,
    duty_level:  RST_START_DUTY,
    prev_level:  1'b0,
    down_turn:   1'b0,
    drive:       DRIVE_OFF
  };

  // Closed loop once past the open loop start
  localparam int CLOSED_LOOP_DELAY = 12;
  localparam int STAGE_DELAY_STEP  = 3;

endpackage

### rtl/core/sbc_cfg_regs.sv
// ----------------------------------------------------------------------------
// sbc_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module sbc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [2:0]                    wr_index,
  input  logic [sbc_pkg::CFG_DATA_W-1:0] wr_data,
  output sbc_pkg::cfg_t                 cfg
);

  sbc_pkg::cfg_t cfg_r;
  sbc_pkg::cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        sbc_pkg::CFG_MIN_DUTY:         cfg_nxt.min_duty = wr_data[7:0];
        sbc_pkg::CFG_MAX_DUTY:         cfg_nxt.max_duty = wr_data[7:0];
        sbc_pkg::CFG_START_DUTY:       cfg_nxt.start_duty = wr_data[7:0];
        sbc_pkg::CFG_DUTY_INCREMENT:   cfg_nxt.duty_increment = wr_data[5:0];
        sbc_pkg::CFG_DEBOUNCE_SAMPLES: cfg_nxt.debounce_samples = wr_data[3:0];
        sbc_pkg::CFG_FIRST_DELAY_MS:   cfg_nxt.first_start_delay_ms = wr_data[5:0];
        sbc_pkg::CFG_STEPS_PER_STAGE:  cfg_nxt.steps_per_stage = wr_data[5:0];
        sbc_pkg::CFG_BUTTON_REPEAT_MS: cfg_nxt.button_repeat_ms = wr_data[9:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{min_duty:             sbc_pkg::RST_MIN_DUTY,
                 max_duty:             sbc_pkg::RST_MAX_DUTY,
                 start_duty:           sbc_pkg::RST_START_DUTY,
                 duty_increment:       sbc_pkg::RST_DUTY_INCREMENT,
                 debounce_samples:     sbc_pkg::RST_DEBOUNCE_SAMPLES,
                 first_start_delay_ms: sbc_pkg::RST_FIRST_DELAY_MS,
                 steps_per_stage:      sbc_pkg::RST_STEPS_PER_STAGE,
                 button_repeat_ms:     sbc_pkg::RST_BUTTON_REPEAT_MS};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/sbc_step.sv
// ----------------------------------------------------------------------------
// sbc_step
// Next-state logic for one comparator sample: open loop start sequencing,
// back-EMF edge debounce, commutation and button duty control.
// ----------------------------------------------------------------------------
module sbc_step (
  input  sbc_pkg::cfg_t   cfg,
  input  sbc_pkg::state_t cur,
  input  logic            comparator_level,
  input  logic            speed_up_pressed,
  input  logic            speed_down_pressed,
  input  logic            ms_tick,
  output sbc_pkg::state_t nxt,
  output logic            did_commutate
);

  // Six-step drive table, high/low/sense/rising
  function automatic sbc_pkg::drive_t step_pattern(input logic [2:0] step);
    sbc_pkg::drive_t p;
    unique case (step)
      3'd1:    p = '{sbc_pkg::PHASE_A, sbc_pkg::PHASE_C, sbc_pkg::PHASE_B, 1'b0};
      3'd2:    p = '{sbc_pkg::PHASE_B, sbc_pkg::PHASE_C, sbc_pkg::PHASE_A, 1'b1};
      3'd3:    p = '{sbc_pkg::PHASE_B, sbc_pkg::PHASE_A, sbc_pkg::PHASE_C, 1'b0};
      3'd4:    p = '{sbc_pkg::PHASE_C, sbc_pkg::PHASE_A, sbc_pkg::PHASE_B, 1'b1};
      3'd5:    p = '{sbc_pkg::PHASE_C, sbc_pkg::PHASE_B, sbc_pkg::PHASE_A, 1'b0};
      default: p = '{sbc_pkg::PHASE_A, sbc_pkg::PHASE_B, sbc_pkg::PHASE_C, 1'b1};
    endcase
    return p;
  endfunction

  // Min test first, then max test
  function automatic logic [7:0] clamp_duty(input logic signed [9:0] v,
                                            input logic [7:0] lo,
                                            input logic [7:0] hi);
    logic signed [9:0] r;
    r = v;
    if (r < $signed({2'b00, lo})) r = $signed({2'b00, lo});
    if (r > $signed({2'b00, hi})) r = $signed({2'b00, hi});
    return r[7:0];
  endfunction

  logic [2:0]        eff_step;
  logic [3:0]        need;
  logic              expect_level;
  logic signed [9:0] duty_up;
  logic signed [9:0] duty_dn;
  logic              did;

  assign eff_step = (cur.step_index > 3'd5) ? 3'd0 : cur.step_index;
  assign need     = (cfg.debounce_samples == 4'd0) ? 4'd1 : cfg.debounce_samples;
  assign duty_up  = $signed({2'b00, cur.duty_level}) + $signed({4'b0000, cfg.duty_increment});
  assign duty_dn  = $signed({2'b00, cur.duty_level}) - $signed({4'b0000, cfg.duty_increment});

  always_comb begin
    nxt          = cur;
    did          = 1'b0;
    expect_level = 1'b0;

    // Count down the open loop wait
    if (nxt.mode == sbc_pkg::MODE_START_WAIT) begin
      if (ms_tick && nxt.wait_count != 10'd0) nxt.wait_count = nxt.wait_count - 10'd1;
      if (nxt.wait_count == 10'd0) nxt.mode = sbc_pkg::MODE_START_COMMUTATE;
    end

    // Open loop commutation, or hand over to closed loop
    if (nxt.mode == sbc_pkg::MODE_START_COMMUTATE) begin
      if (nxt.stage_delay > 6'(sbc_pkg::CLOSED_LOOP_DELAY)) begin
        nxt.drive       = step_pattern(eff_step);
        nxt.step_index  = (eff_step == 3'd5) ? 3'd0 : eff_step + 3'd1;
        did             = 1'b1;
        nxt.wait_count  = {4'b0000, nxt.stage_delay};
        nxt.stage_count = nxt.stage_count + 6'd1;
        if (nxt.stage_count >= cfg.steps_per_stage) begin
          nxt.stage_delay = nxt.stage_delay - 6'(sbc_pkg::STAGE_DELAY_STEP);
          nxt.stage_count = 6'd0;
        end
        nxt.mode = sbc_pkg::MODE_START_WAIT;
      end else begin
        nxt.mode        = sbc_pkg::MODE_RUN_EDGE;
        nxt.match_count = 4'd0;
        nxt.wait_count  = 10'd0;
      end
    end

    if (nxt.mode == sbc_pkg::MODE_START_WAIT) begin
      // Hold start duty during open loop
      nxt.duty_level = clamp_duty($signed({2'b00, cfg.start_duty}), cfg.min_duty,
                                  cfg.max_duty);
    end else if (!did) begin
      expect_level = nxt.step_index[0];

      // Detect the expected edge, then debounce
      if (nxt.mode == sbc_pkg::MODE_RUN_EDGE) begin
        if (cur.prev_level != comparator_level && comparator_level == expect_level) begin
          nxt.match_count = 4'd1;
          nxt.mode        = sbc_pkg::MODE_RUN_COUNT;
        end
      end else if (comparator_level == expect_level) begin
        nxt.match_count = nxt.match_count + 4'd1;
      end

      // Closed loop commutation
      if (nxt.mode == sbc_pkg::MODE_RUN_COUNT && nxt.match_count >= need) begin
        nxt.drive       = step_pattern(eff_step);
        nxt.step_index  = (eff_step == 3'd5) ? 3'd0 : eff_step + 3'd1;
        did             = 1'b1;
        nxt.match_count = 4'd0;
        nxt.mode        = sbc_pkg::MODE_RUN_EDGE;
      end

      // Buttons, alternating up and down checks after the hold-off
      if (nxt.wait_count != 10'd0) begin
        if (ms_tick) nxt.wait_count = nxt.wait_count - 10'd1;
      end else if (!nxt.down_turn) begin
        if (speed_up_pressed && nxt.duty_level < cfg.max_duty) begin
          nxt.duty_level = clamp_duty(duty_up, cfg.min_duty, cfg.max_duty);
          nxt.wait_count = cfg.button_repeat_ms;
        end
        nxt.down_turn = 1'b1;
      end else begin
        if (speed_down_pressed && nxt.duty_level > cfg.min_duty) begin
          nxt.duty_level = clamp_duty(duty_dn, cfg.min_duty, cfg.max_duty);
          nxt.wait_count = cfg.button_repeat_ms;
        end
        nxt.down_turn = 1'b0;
      end
    end

    nxt.prev_level = comparator_level;
  end

  assign did_commutate = did;

endmodule

### rtl/core/sensorless_bldc_commutator.sv
// The result of an accepted sample is held in the output register from the next cycle.
// Throughput: one sample per cycle while the result channel is not stalled; the state update is one pass of sbc_step.
// The input is taken whenever the output register is empty or being drained.
// Reset (rst_n low, synchronous) loads the register defaults, starts open loop
// at step 0 with all switches off, and empties the output register.
// ----------------------------------------------------------------------------
// sensorless_bldc_commutator
// Six-step sensorless BLDC controller, one transaction per comparator sample.
// ----------------------------------------------------------------------------
module sensorless_bldc_commutator (
  input  logic                           clk,
  input  logic                           rst_n,
  // comparator sample channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_comparator_level,
  input  logic                           in_speed_up_pressed,
  input  logic                           in_speed_down_pressed,
  input  logic                           in_ms_tick,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_high_side_phase,
  output logic [1:0]                     out_low_side_phase,
  output logic [1:0]                     out_sense_phase,
  output logic                           out_sense_rising,
  output logic [7:0]                     out_pwm_duty,
  output logic                           out_closed_loop,
  output logic                           out_commutated,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [2:0]                     cfg_index,
  input  logic [sbc_pkg::CFG_DATA_W-1:0] cfg_data
);

  sbc_pkg::cfg_t   cfg;
  sbc_pkg::state_t state_r;
  sbc_pkg::state_t state_nxt;
  logic            did;
  logic            in_accept;
  logic            out_valid_r;
  logic            closed_nxt;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  sbc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sbc_step u_step (
    .cfg                (cfg),
    .cur                (state_r),
    .comparator_level   (in_comparator_level),
    .speed_up_pressed   (in_speed_up_pressed),
    .speed_down_pressed (in_speed_down_pressed),
    .ms_tick            (in_ms_tick),
    .nxt                (state_nxt),
    .did_commutate      (did)
  );

  assign closed_nxt = (state_nxt.mode == sbc_pkg::MODE_RUN_EDGE) ||
                      (state_nxt.mode == sbc_pkg::MODE_RUN_COUNT);

  // Advance controller state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbc_pkg::STATE_RESET;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_high_side_phase <= state_nxt.drive.high_side;
      out_low_side_phase  <= state_nxt.drive.low_side;
      out_sense_phase     <= state_nxt.drive.sense;
      out_sense_rising    <= state_nxt.drive.rising;
      out_pwm_duty        <= state_nxt.duty_level;
      out_closed_loop     <= closed_nxt;
      out_commutated      <= did;
    end
  end

  assign out_valid = out_valid_r;

  // Step index stays within the six patterns
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.step_index <= 3'd5)
    else $error("step index out of range");

  // A stalled result blocks the next sample
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted over a stalled result");

  // Closed loop is never left again
  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == sbc_pkg::MODE_RUN_EDGE || state_r.mode == sbc_pkg::MODE_RUN_COUNT)
    |=> (state_r.mode == sbc_pkg::MODE_RUN_EDGE || state_r.mode == sbc_pkg::MODE_RUN_COUNT))
    else $error("left closed loop");

  // Every accepted sample yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted sample produced no result");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensorless BLDC six-step commutator. A cycle
// accurate predictor tracks the open loop start, back-EMF debounce and duty
// buttons for every accepted comparator sample, and each result transaction
// is compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import sbc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 8;
  localparam int PRESS_PCT   = 40;

  typedef struct packed {
    logic [1:0] high_side;
    logic [1:0] low_side;
    logic [1:0] sense;
    logic       rising;
    logic [7:0] duty;
    logic       closed_loop;
    logic       commutated;
  } drive_sample_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_comparator_level;
  logic       in_speed_up_pressed;
  logic       in_speed_down_pressed;
  logic       in_ms_tick;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_high_side_phase;
  logic [1:0] out_low_side_phase;
  logic [1:0] out_sense_phase;
  logic       out_sense_rising;
  logic [7:0] out_pwm_duty;
  logic       out_closed_loop;
  logic       out_commutated;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of the register file
  logic [7:0] reg_min_duty, reg_max_duty, reg_start_duty;
  logic [5:0] reg_duty_inc, reg_first_delay, reg_steps_per_stage;
  logic [3:0] reg_debounce;
  logic [9:0] reg_repeat_ms;

  // Predictor copy of the controller state
  logic [2:0] st_step;
  mode_t      st_mode;
  logic [5:0] st_stage_delay, st_stage_count;
  logic [9:0] st_wait;
  logic [3:0] st_match;
  logic [7:0] st_duty;
  logic       st_prev_level, st_down_turn;
  drive_t     st_drive;

  drive_sample_t pending_drive_q[$];
  int            fail_count  = 0;
  int            cycle_count = 0;
  logic          steady      = 1'b0;
  logic          run_level   = 1'b0;
  int            run_left    = 0;

  sensorless_bldc_commutator u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_comparator_level   (in_comparator_level),
    .in_speed_up_pressed   (in_speed_up_pressed),
    .in_speed_down_pressed (in_speed_down_pressed),
    .in_ms_tick            (in_ms_tick),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_high_side_phase   (out_high_side_phase),
    .out_low_side_phase    (out_low_side_phase),
    .out_sense_phase       (out_sense_phase),
    .out_sense_rising      (out_sense_rising),
    .out_pwm_duty          (out_pwm_duty),
    .out_closed_loop       (out_closed_loop),
    .out_commutated        (out_commutated),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Six-step table: high side, low side, floating sense phase, rising edge
  function automatic drive_t pattern_for(logic [2:0] s);
    drive_t d;
    case (s)
      3'd0:    d = {PHASE_A, PHASE_B, PHASE_C, 1'b1};
      3'd1:    d = {PHASE_A, PHASE_C, PHASE_B, 1'b0};
      3'd2:    d = {PHASE_B, PHASE_C, PHASE_A, 1'b1};
      3'd3:    d = {PHASE_B, PHASE_A, PHASE_C, 1'b0};
      3'd4:    d = {PHASE_C, PHASE_A, PHASE_B, 1'b1};
      default: d = {PHASE_C, PHASE_B, PHASE_A, 1'b0};
    endcase
    return d;
  endfunction

  // Min test first, then max, so an inverted window yields max_duty
  function automatic logic [7:0] clamp_duty(int v);
    if (v < int'(reg_min_duty)) v = int'(reg_min_duty);
    if (v > int'(reg_max_duty)) v = int'(reg_max_duty);
    return v[7:0];
  endfunction

  task automatic commutate_phases();
    if (st_step > 3'd5) st_step = 3'd0;
    st_drive = pattern_for(st_step);
    st_step  = (st_step == 3'd5) ? 3'd0 : st_step + 3'd1;
  endtask

  task automatic reset_commutator();
    reg_min_duty        = RST_MIN_DUTY;
    reg_max_duty        = RST_MAX_DUTY;
    reg_start_duty      = RST_START_DUTY;
    reg_duty_inc        = RST_DUTY_INCREMENT;
    reg_debounce        = RST_DEBOUNCE_SAMPLES;
    reg_first_delay     = RST_FIRST_DELAY_MS;
    reg_steps_per_stage = RST_STEPS_PER_STAGE;
    reg_repeat_ms       = RST_BUTTON_REPEAT_MS;
    st_step        = 3'd0;
    st_mode        = MODE_START_COMMUTATE;
    st_stage_delay = RST_FIRST_DELAY_MS;
    st_stage_count = 6'd0;
    st_wait        = 10'd0;
    st_match       = 4'd0;
    st_duty        = RST_START_DUTY;
    st_prev_level  = 1'b0;
    st_down_turn   = 1'b0;
    st_drive       = DRIVE_OFF;
  endtask

  task automatic write_shadow_reg(cfg_index_t idx, logic [9:0] v);
    case (idx)
      CFG_MIN_DUTY:         reg_min_duty        = v[7:0];
      CFG_MAX_DUTY:         reg_max_duty        = v[7:0];
      CFG_START_DUTY:       reg_start_duty      = v[7:0];
      CFG_DUTY_INCREMENT:   reg_duty_inc        = v[5:0];
      CFG_DEBOUNCE_SAMPLES: reg_debounce        = v[3:0];
      CFG_FIRST_DELAY_MS:   reg_first_delay     = v[5:0];
      CFG_STEPS_PER_STAGE:  reg_steps_per_stage = v[5:0];
      default:              reg_repeat_ms       = v[9:0];
    endcase
  endtask

  function automatic bit in_open_loop();
    return st_mode == MODE_START_COMMUTATE || st_mode == MODE_START_WAIT;
  endfunction

  // Advance the controller by one comparator sample and form its result
  task automatic advance_commutator(input logic lvl, input logic up, input logic dn,
                                    input logic tick, output drive_sample_t r);
    logic       did;
    logic       want_level;
    logic [3:0] need;
    did  = 1'b0;
    need = (reg_debounce == 4'd0) ? 4'd1 : reg_debounce;

    // Count down the open loop wait
    if (st_mode == MODE_START_WAIT) begin
      if (tick && st_wait > 10'd0) st_wait = st_wait - 10'd1;
      if (st_wait == 10'd0) st_mode = MODE_START_COMMUTATE;
    end

    // Forced commutation, or hand over to closed loop once the delay is short
    if (st_mode == MODE_START_COMMUTATE) begin
      if (st_stage_delay > CLOSED_LOOP_DELAY) begin
        commutate_phases();
        did            = 1'b1;
        st_wait        = 10'(st_stage_delay);
        st_stage_count = st_stage_count + 6'd1;
        if (st_stage_count >= reg_steps_per_stage) begin
          st_stage_delay = st_stage_delay - 6'(STAGE_DELAY_STEP);
          st_stage_count = 6'd0;
        end
        st_mode = MODE_START_WAIT;
      end else begin
        st_mode  = MODE_RUN_EDGE;
        st_match = 4'd0;
        st_wait  = 10'd0;
      end
    end

    if (in_open_loop()) begin
      st_duty = clamp_duty(int'(reg_start_duty));
    end else if (!did) begin
      // Back-EMF edge detect and debounce
      want_level = st_step[0];
      if (st_mode == MODE_RUN_EDGE) begin
        if (st_prev_level != lvl && lvl == want_level) begin
          st_match = 4'd1;
          st_mode  = MODE_RUN_COUNT;
        end
      end else if (lvl == want_level) begin
        st_match = st_match + 4'd1;
      end
      if (st_mode == MODE_RUN_COUNT && st_match >= need) begin
        commutate_phases();
        did      = 1'b1;
        st_match = 4'd0;
        st_mode  = MODE_RUN_EDGE;
      end

      // Buttons: hold-off, else alternate the up and down checks
      if (st_wait > 10'd0) begin
        if (tick) st_wait = st_wait - 10'd1;
      end else if (!st_down_turn) begin
        if (up && st_duty < reg_max_duty) begin
          st_duty = clamp_duty(int'(st_duty) + int'(reg_duty_inc));
          st_wait = reg_repeat_ms;
        end
        st_down_turn = 1'b1;
      end else begin
        if (dn && st_duty > reg_min_duty) begin
          st_duty = clamp_duty(int'(st_duty) - int'(reg_duty_inc));
          st_wait = reg_repeat_ms;
        end
        st_down_turn = 1'b0;
      end
    end

    st_prev_level = lvl;

    r.high_side   = st_drive.high_side;
    r.low_side    = st_drive.low_side;
    r.sense       = st_drive.sense;
    r.rising      = st_drive.rising;
    r.duty        = st_duty;
    r.closed_loop = !in_open_loop();
    r.commutated  = did;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one comparator sample; called and returns at a falling edge
  task automatic send_sample(input logic lvl, input logic up, input logic dn,
                             input logic tick);
    drive_sample_t r;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid              <= 1'b1;
    in_comparator_level   <= lvl;
    in_speed_up_pressed   <= up;
    in_speed_down_pressed <= dn;
    in_ms_tick            <= tick;
    do @(posedge clk); while (!in_ready);
    advance_commutator(lvl, up, dn, tick, r);
    pending_drive_q.push_back(r);
    @(negedge clk);
  endtask

  // Write one register; leaves cfg_valid high so back-to-back writes stream
  task automatic write_reg(input cfg_index_t idx, input logic [9:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    write_shadow_reg(idx, v);
    @(negedge clk);
  endtask

  // Hold the sample channel and wait for every pending result
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_drive_q.size() != 0);
  endtask

  // Comparator waveform: alternating runs, mostly long enough to debounce
  task automatic next_level(output logic lvl);
    int need;
    need = (reg_debounce == 4'd0) ? 1 : int'(reg_debounce);
    if (run_left == 0) begin
      run_level = ~run_level;
      run_left  = ($urandom_range(99) < 20) ? $urandom_range(need, 1)
                                            : $urandom_range(need + 4, need);
    end
    run_left = run_left - 1;
    lvl = ($urandom_range(99) < 8) ? ~run_level : run_level;
  endtask

  // Stall the result channel at random except during steady stretches
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    drive_sample_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_drive_q.size() == 0) begin
        $error("result transaction with no sample pending");
        fail_count++;
      end else begin
        want = pending_drive_q.pop_front();
        check_field("high_side_phase", want.high_side, out_high_side_phase);
        check_field("low_side_phase", want.low_side, out_low_side_phase);
        check_field("sense_phase", want.sense, out_sense_phase);
        check_field("sense_rising", want.rising, out_sense_rising);
        check_field("pwm_duty", want.duty, out_pwm_duty);
        check_field("closed_loop", want.closed_loop, out_closed_loop);
        check_field("commutated", want.commutated, out_commutated);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Forced start: zero steps per stage shortens the delay after every
  // commutation; an oversized start duty is clamped to max_duty
  task automatic test_open_loop_start();
    logic lvl;
    write_reg(CFG_STEPS_PER_STAGE, 10'd0);
    write_reg(CFG_START_DUTY, 10'd255);
    cfg_valid <= 1'b0;
    // Every input combination, buttons ignored while starting
    for (int i = 0; i < 8; i++) begin
      send_sample(i[0], i[1], i[2], i[0] ^ i[2]);
    end
    // Run the waits out until the short delay hands over to closed loop
    while (in_open_loop()) begin
      lvl = $urandom_range(1);
      send_sample(lvl, $urandom_range(1), $urandom_range(1), $urandom_range(99) < 75);
    end
    wait_drained();
  endtask

  // Duty extremes: full range with the largest step, then an inverted window
  task automatic test_duty_clamp();
    write_reg(CFG_MIN_DUTY, 10'd0);
    write_reg(CFG_MAX_DUTY, 10'd255);
    write_reg(CFG_DUTY_INCREMENT, 10'd63);
    write_reg(CFG_BUTTON_REPEAT_MS, 10'd0);
    cfg_valid <= 1'b0;
    repeat (6) send_sample(1'b0, 1'b1, 1'b0, 1'b1);
    repeat (10) send_sample(1'b0, 1'b0, 1'b1, 1'b0);
    wait_drained();
    write_reg(CFG_MIN_DUTY, 10'd200);
    write_reg(CFG_MAX_DUTY, 10'd100);
    cfg_valid <= 1'b0;
    repeat (2) send_sample(1'b1, 1'b1, 1'b1, 1'b1);
    wait_drained();
  endtask

  // Closed loop running with random comparator waveforms and buttons
  task automatic test_closed_loop(input int n, input int min_d, input int max_d,
                                  input int start_d, input int inc, input int deb,
                                  input int first_ms, input int steps,
                                  input int repeat_ms, input int tick_pct);
    logic lvl;
    write_reg(CFG_MIN_DUTY, 10'(min_d));
    write_reg(CFG_MAX_DUTY, 10'(max_d));
    write_reg(CFG_START_DUTY, 10'(start_d));
    write_reg(CFG_DUTY_INCREMENT, 10'(inc));
    write_reg(CFG_DEBOUNCE_SAMPLES, 10'(deb));
    write_reg(CFG_FIRST_DELAY_MS, 10'(first_ms));
    write_reg(CFG_STEPS_PER_STAGE, 10'(steps));
    write_reg(CFG_BUTTON_REPEAT_MS, 10'(repeat_ms));
    cfg_valid <= 1'b0;
    repeat (n) begin
      next_level(lvl);
      send_sample(lvl, $urandom_range(99) < PRESS_PCT, $urandom_range(99) < PRESS_PCT,
                  $urandom_range(99) < tick_pct);
    end
    wait_drained();
  endtask

  task automatic test_random_settings(input int n);
    int lo;
    lo = $urandom_range(255);
    test_closed_loop(n, lo, $urandom_range(255, lo), $urandom_range(255),
                     $urandom_range(63, 1), $urandom_range(15), $urandom_range(63, 1),
                     $urandom_range(63, 1), $urandom_range(7), $urandom_range(80, 20));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                 = 1'b0;
    in_valid              = 1'b0;
    in_comparator_level   = 1'b0;
    in_speed_up_pressed   = 1'b0;
    in_speed_down_pressed = 1'b0;
    in_ms_tick            = 1'b0;
    cfg_valid             = 1'b0;
    cfg_index             = CFG_MIN_DUTY;
    cfg_data              = '0;
    reset_commutator();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_open_loop_start();
    test_duty_clamp();

    // No idling on either side through this stretch
    steady = 1'b1;
    test_closed_loop(300, 0, 255, 0, 63, 1, 1, 1, 0, 50);
    steady = 1'b0;
    test_closed_loop(300, 200, 100, 255, 1, 15, 63, 63, 1, 50);
    test_closed_loop(300, RST_MIN_DUTY, RST_MAX_DUTY, RST_START_DUTY, RST_DUTY_INCREMENT,
                     RST_DEBOUNCE_SAMPLES, RST_FIRST_DELAY_MS, RST_STEPS_PER_STAGE,
                     RST_BUTTON_REPEAT_MS, 90);
    test_closed_loop(200, 255, 255, 37, 7, 0, 40, 0, 1023, 95);
    repeat (3) test_random_settings(120);

    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_drive_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### sensorless_bldc_commutator.f
rtl/core/sbc_pkg.sv
rtl/core/sbc_cfg_regs.sv
rtl/core/sbc_step.sv
rtl/core/sensorless_bldc_commutator.sv
sim/tb_top.sv
